// ===== rtl/mdf_pkg.sv =====
// Shared types, constants and saturation helper for the modulated delay flanger.
`timescale 1ns / 1ps

package mdf_pkg;

  localparam int unsigned DEPTH_DEF    = 4096;
  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 8;

  // Feedback gain is held at or below 0.99 in unsigned Q0.15.
  localparam logic [14:0] FB_CAP = 15'd32440;

  localparam logic signed [15:0] FF_GAIN_RST = 16'sd16384;
  localparam logic [14:0]        FB_GAIN_RST = 15'd0;
  localparam logic [11:0]        BASE_RST    = 12'd4;

  typedef enum logic [1:0] {
    REG_FF_GAIN = 2'd0,
    REG_FB_GAIN = 2'd1,
    REG_BASE    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // Stage strobes handed from the sequencer to every channel lane.
  typedef struct packed {
    logic ld_x0;
    logic ld_tap;
    logic ld_prod;
    logic wr_en;
    logic rd_live;
  } lane_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
    logic signed [15:0] res;
    if (x > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (x < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mdf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mdf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mdf_lane.sv =====
// One channel: delay line memory, linear interpolation, gains and write-back.
`timescale 1ns / 1ps

module mdf_lane #(
  parameter int unsigned DEPTH = mdf_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  mdf_pkg::lane_ctrl_t      ctrl_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [7:0]               frac_i,
  input  logic [14:0]              fb_gain_i,
  input  logic signed [15:0]       ff_gain_i,
  input  logic signed [15:0]       sample_i,
  output logic signed [15:0]       y_o
);

  logic [15:0]        rdata;
  logic signed [15:0] x_rd;
  logic signed [15:0] x0_q;
  logic signed [16:0] diff;
  logic signed [25:0] ip;
  logic signed [15:0] tap_d;
  logic signed [15:0] tap_q;
  logic signed [31:0] fbp_d, fbp_q;
  logic signed [31:0] ffp_d, ffp_q;
  logic signed [18:0] wsum;
  logic signed [18:0] ysum;
  logic signed [15:0] wval;

  mdf_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wval),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // Entries not yet written since reset read as zero.
  assign x_rd = ctrl_i.rd_live ? $signed(rdata) : 16'sd0;

  assign diff  = {x_rd[15], x_rd} - {x0_q[15], x0_q};
  assign ip    = $signed({1'b0, frac_i}) * diff;
  // The interpolated tap always fits in 16 bits, so the low bits suffice.
  assign tap_d = x0_q + ip[23:8];

  assign fbp_d = $signed({1'b0, fb_gain_i}) * tap_q;
  assign ffp_d = ff_gain_i * tap_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_x0) begin
      x0_q <= x_rd;
    end
    if (ctrl_i.ld_tap) begin
      tap_q <= tap_d;
    end
    if (ctrl_i.ld_prod) begin
      fbp_q <= fbp_d;
      ffp_q <= ffp_d;
    end
  end

  assign wsum = {{3{sample_i[15]}}, sample_i} + {{2{fbp_q[31]}}, fbp_q[31:15]};
  assign ysum = {{3{sample_i[15]}}, sample_i} + {ffp_q[31], ffp_q[31:14]};
  assign wval = mdf_pkg::sat16(wsum);
  assign y_o  = mdf_pkg::sat16(ysum);

endmodule

// ===== rtl/modulated_delay_flanger_top.sv =====
// Top level: config registers, read-point sequencer, channel lanes and output register.
// The sequencer steps through address computation, two reads of the single read port per
// delay line, interpolation, gains and write-back; a new item is accepted only in idle,
// and write-back waits while the output register holds a result not yet taken.
// Reset clears all control state; the delay lines read as zero until written, tracked
// by the write index and a wrap flag, so no clearing pass is needed after reset.
`timescale 1ns / 1ps

module modulated_delay_flanger_top #(
  parameter int unsigned DEPTH    = mdf_pkg::DEPTH_DEF,
  parameter int unsigned CHANNELS = mdf_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // left_in[15:0], right_in[31:16], mod_offset[47:32]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // left_out[15:0], right_out[31:16]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = ((AW > 12) ? AW : 12) + 10;
  localparam int unsigned NL = (CHANNELS < 2) ? CHANNELS : 2;

  localparam logic signed [DW-1:0] D_LO   = DW'(256);
  localparam logic signed [DW-1:0] D_HI   = DW'((DEPTH - 2) * 256);
  localparam logic signed [DW-1:0] R_WRAP = DW'(DEPTH * 256);
  localparam logic [AW-1:0]        LAST   = AW'(DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADDR = 7'b0000010,
    S_RD0  = 7'b0000100,
    S_RD1  = 7'b0001000,
    S_INTP = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_WR   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] ff_gain_q;
  logic [14:0]        fb_gain_q;
  logic [11:0]        base_q;

  logic signed [15:0] samp_q [2];
  logic signed [15:0] mod_q;

  logic [AW-1:0] wi_q;
  logic          wrapped_q;
  logic [AW-1:0] i0_q, i1_q;
  logic [7:0]    f_q;
  logic          rd_live_q;

  logic          out_valid_q;
  logic [31:0]   out_data_q;

  logic signed [DW-1:0] d_raw, d_clamp, r_raw, r_pos;
  logic [AW-1:0]        i0_d, i1_d;
  logic [AW-1:0]        rd_addr;
  logic                 in_fire, wr_fire;
  mdf_pkg::lane_ctrl_t  ctrl;
  logic signed [15:0]   lane_y [2];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign wr_fire       = (state_q == S_WR) & (~out_valid_q | m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_gain_q <= mdf_pkg::FF_GAIN_RST;
      fb_gain_q <= mdf_pkg::FB_GAIN_RST;
      base_q    <= mdf_pkg::BASE_RST;
    end else if (cfg_valid_i) begin
      unique case (mdf_pkg::reg_idx_e'(cfg_index_i))
        mdf_pkg::REG_FF_GAIN: ff_gain_q <= $signed(cfg_data_i);
        mdf_pkg::REG_FB_GAIN: begin
          fb_gain_q <= (cfg_data_i[14:0] > mdf_pkg::FB_CAP) ? mdf_pkg::FB_CAP
                                                            : cfg_data_i[14:0];
        end
        mdf_pkg::REG_BASE:    base_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Read point: total delay clamped to one sample up to DEPTH-2 samples behind the write index.
  always_comb begin
    d_raw = $signed({{(DW-20){1'b0}}, base_q, 8'h00})
          + $signed({{(DW-16){mod_q[15]}}, mod_q});
    if (d_raw < D_LO) begin
      d_clamp = D_LO;
    end else if (d_raw > D_HI) begin
      d_clamp = D_HI;
    end else begin
      d_clamp = d_raw;
    end
    r_raw = $signed({{(DW-AW-8){1'b0}}, wi_q, 8'h00}) - d_clamp;
    r_pos = (r_raw < 0) ? (r_raw + R_WRAP) : r_raw;
    i0_d  = r_pos[AW+7:8];
    i1_d  = (i0_d == LAST) ? '0 : (i0_d + 1'b1);
  end

  assign rd_addr = (state_q == S_RD1) ? i1_q : i0_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_ADDR;
      S_ADDR:  state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_INTP;
      S_INTP:  state_d = S_MUL;
      S_MUL:   state_d = S_WR;
      S_WR:    if (wr_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      wrapped_q   <= 1'b0;
      rd_live_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_live_q <= wrapped_q | (rd_addr < wi_q);
      if (wr_fire) begin
        wi_q <= (wi_q == LAST) ? '0 : (wi_q + 1'b1);
        if (wi_q == LAST) begin
          wrapped_q <= 1'b1;
        end
      end
      if (wr_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q[0] <= $signed(s_axis_tdata[15:0]);
      samp_q[1] <= $signed(s_axis_tdata[31:16]);
      mod_q     <= $signed(s_axis_tdata[47:32]);
    end
    if (state_q == S_ADDR) begin
      i0_q <= i0_d;
      i1_q <= i1_d;
      f_q  <= r_pos[7:0];
    end
    if (wr_fire) begin
      out_data_q <= {lane_y[1], lane_y[0]};
    end
  end

  assign ctrl.ld_x0   = (state_q == S_RD1);
  assign ctrl.ld_tap  = (state_q == S_INTP);
  assign ctrl.ld_prod = (state_q == S_MUL);
  assign ctrl.wr_en   = wr_fire;
  assign ctrl.rd_live = rd_live_q;

  for (genvar c = 0; c < 2; c++) begin : g_lane
    if (c < NL) begin : g_on
      mdf_lane #(
        .DEPTH (DEPTH)
      ) u_lane (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .rd_addr_i (rd_addr),
        .wr_addr_i (wi_q),
        .frac_i    (f_q),
        .fb_gain_i (fb_gain_q),
        .ff_gain_i (ff_gain_q),
        .sample_i  (samp_q[c]),
        .y_o       (lane_y[c])
      );
    end else begin : g_off
      assign lane_y[c] = 16'sd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
